// ===== design/pdct_pkg.sv =====
// Shared types and constants of the pointer drag and click tracker.
package pdct_pkg;

	localparam logic [1:0] ACT_MOVE    = 2'd0;
	localparam logic [1:0] ACT_PRESS   = 2'd1;
	localparam logic [1:0] ACT_RELEASE = 2'd2;

	localparam logic [1:0] KIND_DRAG   = 2'd0;
	localparam logic [1:0] KIND_CLICK  = 2'd1;
	localparam logic [1:0] KIND_DOUBLE = 2'd2;

	localparam logic [15:0] WINDOW_RESET = 16'd500;

	localparam int IN_DATA_W  = 72;
	localparam int OUT_DATA_W = 136;

	typedef enum logic [3:0] {
		ST_IDLE   = 4'b0001,
		ST_SCAN   = 4'b0010,
		ST_EXEC   = 4'b0100,
		ST_DOUBLE = 4'b1000
	} state_t;

	typedef struct packed {
		logic [15:0] start_x;
		logic [15:0] start_y;
		logic [15:0] last_x;
		logic [15:0] last_y;
		logic [31:0] start_time;
		logic [15:0] click_x;
		logic [15:0] click_y;
		logic [31:0] click_time;
	} entry_t;

endpackage

// ===== design/pointer_drag_click_tracker_unit.sv =====
// Top level of the pointer drag and click tracker with its per-button state memory.
//
// The per-button drag and click state lives in one synchronous memory, one entry per
// button, with a written bit per entry so that unwritten entries read as zero. Every
// access is a registered read, then a modify and write back, so an item is finished
// before the next one is taken. A press or release reads and writes only its own
// button, and a release that makes a double click emits a second result after the
// click. A move walks the buttons from index zero up to the highest held one and
// updates and reports every held button. An ignored item touches no entry.
// Results wait in an output register and stall the walk only while it is still full.
module pointer_drag_click_tracker_unit #(
	parameter int BUTTON_COUNT = 8
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_axis_tvalid,
	output logic                           s_axis_tready,
	// x, y, button_index, timestamp, zero fill
	input  logic [pdct_pkg::IN_DATA_W-1:0]  s_axis_tdata,
	// action
	input  logic [1:0]                     s_axis_tuser,
	output logic                           m_axis_tvalid,
	input  logic                           m_axis_tready,
	// button, pos_x, pos_y, step_dx, step_dy, start_x, start_y, time_value, zero fill
	output logic [pdct_pkg::OUT_DATA_W-1:0] m_axis_tdata,
	// kind
	output logic [1:0]                     m_axis_tuser,
	output logic                           m_axis_tlast,
	input  logic                           cfg_wr_en,
	input  logic [15:0]                    cfg_wr_data
);
	import pdct_pkg::*;

	localparam int IDX_W = (BUTTON_COUNT > 1) ? $clog2(BUTTON_COUNT) : 1;

	state_t state_q;
	logic [15:0] window_q;
	logic [15:0] ptr_x_q;
	logic [15:0] ptr_y_q;
	logic [1:0] act_q;
	logic [31:0] ts_q;
	logic [IDX_W-1:0] idx_q;
	logic [31:0] gap_q;
	logic [BUTTON_COUNT-1:0] held_q;
	logic [BUTTON_COUNT-1:0] seen_q;
	logic [BUTTON_COUNT-1:0] written_q;

	entry_t mem [BUTTON_COUNT];
	entry_t rd_q;
	entry_t cur;
	entry_t entry_next;

	logic in_accept;
	logic [15:0] in_x;
	logic [15:0] in_y;
	logic [2:0] in_button;
	logic [31:0] in_ts;
	logic in_button_ok;

	logic rd_en;
	logic [IDX_W-1:0] rd_addr;
	logic wr_en;
	logic out_free;
	logic exec_go;
	logic [BUTTON_COUNT-1:0] held_from;
	logic [BUTTON_COUNT-1:0] held_above;

	logic emit;
	logic [1:0] e_kind;
	logic [16:0] e_dx;
	logic [16:0] e_dy;
	logic [15:0] e_sx;
	logic [15:0] e_sy;
	logic [31:0] e_time;
	logic e_last;
	logic [31:0] gap;
	logic dbl;

	logic m_valid_q;
	logic [OUT_DATA_W-1:0] m_data_q;
	logic [1:0] m_user_q;
	logic m_last_q;

	assign in_x = s_axis_tdata[15:0];
	assign in_y = s_axis_tdata[31:16];
	assign in_button = s_axis_tdata[34:32];
	assign in_ts = s_axis_tdata[66:35];
	assign in_button_ok = 32'(in_button) < 32'(BUTTON_COUNT);

	assign s_axis_tready = (state_q == ST_IDLE);
	assign in_accept = s_axis_tvalid && s_axis_tready;
	assign out_free = !m_valid_q || m_axis_tready;

	always_comb begin
		for (int j = 0; j < BUTTON_COUNT; j++) begin
			held_from[j] = held_q[j] && (j >= int'(idx_q));
			held_above[j] = held_q[j] && (j > int'(idx_q));
		end
	end

	always_comb begin
		rd_en = 1'b0;
		rd_addr = idx_q;
		if (state_q == ST_IDLE) begin
			rd_addr = IDX_W'(in_button);
			rd_en = in_accept && (s_axis_tuser == ACT_PRESS || s_axis_tuser == ACT_RELEASE)
				&& in_button_ok;
		end else if (state_q == ST_SCAN) begin
			rd_en = held_q[idx_q];
		end
	end

	always_comb begin
		cur = written_q[idx_q] ? rd_q : '0;
		entry_next = cur;
		e_kind = KIND_DRAG;
		e_dx = '0;
		e_dy = '0;
		e_sx = cur.start_x;
		e_sy = cur.start_y;
		e_time = ts_q;
		e_last = 1'b1;
		gap = ts_q - cur.click_time;
		dbl = seen_q[idx_q] && (cur.click_x == ptr_x_q) && (cur.click_y == ptr_y_q)
			&& (gap <= {16'd0, window_q});
		case (act_q)
			ACT_MOVE: begin
				e_kind = KIND_DRAG;
				e_dx = {ptr_x_q[15], ptr_x_q} - {cur.last_x[15], cur.last_x};
				e_dy = {ptr_y_q[15], ptr_y_q} - {cur.last_y[15], cur.last_y};
				e_time = ts_q - cur.start_time;
				e_last = !(|held_above);
				entry_next.last_x = ptr_x_q;
				entry_next.last_y = ptr_y_q;
			end
			ACT_PRESS: begin
				entry_next.start_x = ptr_x_q;
				entry_next.start_y = ptr_y_q;
				entry_next.last_x = ptr_x_q;
				entry_next.last_y = ptr_y_q;
				entry_next.start_time = ts_q;
			end
			ACT_RELEASE: begin
				e_kind = KIND_CLICK;
				e_dx = {ptr_x_q[15], ptr_x_q} - {cur.start_x[15], cur.start_x};
				e_dy = {ptr_y_q[15], ptr_y_q} - {cur.start_y[15], cur.start_y};
				e_last = !dbl;
				entry_next.last_x = ptr_x_q;
				entry_next.last_y = ptr_y_q;
				entry_next.click_x = ptr_x_q;
				entry_next.click_y = ptr_y_q;
				entry_next.click_time = ts_q;
			end
			default: begin
				e_kind = KIND_DRAG;
			end
		endcase
		if (state_q == ST_DOUBLE) begin
			e_kind = KIND_DOUBLE;
			e_dx = '0;
			e_dy = '0;
			e_sx = '0;
			e_sy = '0;
			e_time = gap_q;
			e_last = 1'b1;
		end
	end

	assign exec_go = out_free || (act_q == ACT_PRESS);
	assign wr_en = (state_q == ST_EXEC) && exec_go;
	assign emit = ((state_q == ST_EXEC) && out_free && (act_q != ACT_PRESS))
		|| ((state_q == ST_DOUBLE) && out_free);

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[idx_q] <= entry_next;
		end
		if (rd_en) begin
			rd_q <= mem[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			window_q <= WINDOW_RESET;
			ptr_x_q <= '0;
			ptr_y_q <= '0;
			act_q <= ACT_MOVE;
			ts_q <= '0;
			idx_q <= '0;
			gap_q <= '0;
			held_q <= '0;
			seen_q <= '0;
			written_q <= '0;
		end else begin
			if (cfg_wr_en) begin
				window_q <= cfg_wr_data;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_accept) begin
						act_q <= s_axis_tuser;
						ts_q <= in_ts;
						if (s_axis_tuser == ACT_MOVE) begin
							ptr_x_q <= in_x;
							ptr_y_q <= in_y;
							idx_q <= '0;
							state_q <= ST_SCAN;
						end else if ((s_axis_tuser == ACT_PRESS || s_axis_tuser == ACT_RELEASE)
							&& in_button_ok) begin
							idx_q <= IDX_W'(in_button);
							state_q <= ST_EXEC;
						end
					end
				end
				ST_SCAN: begin
					if (!(|held_from)) begin
						state_q <= ST_IDLE;
					end else if (held_q[idx_q]) begin
						state_q <= ST_EXEC;
					end else begin
						idx_q <= idx_q + IDX_W'(1);
					end
				end
				ST_EXEC: begin
					if (exec_go) begin
						written_q[idx_q] <= 1'b1;
						case (act_q)
							ACT_MOVE: begin
								if (|held_above) begin
									idx_q <= idx_q + IDX_W'(1);
									state_q <= ST_SCAN;
								end else begin
									state_q <= ST_IDLE;
								end
							end
							ACT_PRESS: begin
								held_q[idx_q] <= 1'b1;
								state_q <= ST_IDLE;
							end
							default: begin
								held_q[idx_q] <= 1'b0;
								seen_q[idx_q] <= 1'b1;
								gap_q <= gap;
								state_q <= dbl ? ST_DOUBLE : ST_IDLE;
							end
						endcase
					end
				end
				ST_DOUBLE: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (emit) begin
			m_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			m_data_q <= {3'd0, e_time, e_sy, e_sx, e_dy, e_dx, ptr_y_q, ptr_x_q, 3'(idx_q)};
			m_user_q <= e_kind;
			m_last_q <= e_last;
		end
	end

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata = m_data_q;
	assign m_axis_tuser = m_user_q;
	assign m_axis_tlast = m_last_q;

`ifndef SYNTHESIS
	a_held_written: assert property (@(posedge clk) disable iff (!arst_n)
		(held_q & ~written_q) == '0)
		else $error("held button without a written entry");

	a_seen_written: assert property (@(posedge clk) disable iff (!arst_n)
		(seen_q & ~written_q) == '0)
		else $error("stored click without a written entry");

	a_double_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && m_axis_tuser == KIND_DOUBLE) |->
		(m_axis_tdata[68:35] == '0 && m_axis_tlast))
		else $error("double click with nonzero delta or not last");
`endif

endmodule
